// ----- sv/sobh_pkg.sv -----
// ----------------------------------------------------------------------------
// sobh_pkg
// Shared widths, register indexes, control types and the line buffer state
// encoding for the 3x3 horizontal Sobel stream filter.
// ----------------------------------------------------------------------------
package sobh_pkg;

  // Fixed field widths
  localparam int PIXEL_W    = 8;
  localparam int ROW_W      = 12;
  localparam int FWIDTH_W   = 10;
  localparam int FHEIGHT_W  = 12;
  localparam int CFG_DATA_W = 12;

  // Line buffer word: upper row in the high byte, middle row in the low byte
  localparam int LB_DATA_W = 2 * PIXEL_W;

  // Output queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Where the arriving pixel sits in the frame
  typedef struct packed {
    logic interior;  // gradient of the pixel up and to the left is ready
    logic border;    // pixel itself is passed through
  } pos_flags_t;

  // Line buffer sequencer
  typedef enum logic [1:0] {
    LB_CLEAR = 2'b01,
    LB_RUN   = 2'b10
  } lb_state_t;

endpackage

// ----- sv/sobh_line_buf.sv -----
// ----------------------------------------------------------------------------
// sobh_line_buf
// Column-indexed store of the two previous rows, one word per column.
// Cleared to zero by a sweep after reset; registered read data.
// ----------------------------------------------------------------------------
module sobh_line_buf #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [sobh_pkg::LB_DATA_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [sobh_pkg::LB_DATA_W-1:0] wr_data,
  output logic                          busy
);

  logic [sobh_pkg::LB_DATA_W-1:0] mem [DEPTH];
  sobh_pkg::lb_state_t            state;
  logic [AW-1:0]                  clr_addr;

  assign busy = (state == sobh_pkg::LB_CLEAR);

  // Sweep every column once after reset, then run
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sobh_pkg::LB_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        sobh_pkg::LB_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= sobh_pkg::LB_RUN;
          end
          clr_addr <= clr_addr + AW'(1);
        end
        sobh_pkg::LB_RUN: begin
          state <= sobh_pkg::LB_RUN;
        end
        default: begin
          state <= sobh_pkg::LB_CLEAR;
        end
      endcase
    end
  end

  // Write port: clear sweep has priority, then the pipeline write-back
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no new pixel is taken
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/sobh_kernel.sv -----
// ----------------------------------------------------------------------------
// sobh_kernel
// Pixel stage register, 3x3 window and the horizontal gradient. Produces
// zero, one or two result entries per pixel and writes the line buffer back.
// ----------------------------------------------------------------------------
module sobh_kernel #(
  parameter int CW = 9,
  parameter int DW = 32,
  parameter int EW = DW + 2
) (
  input  logic                            clk,
  input  logic                            rst,
  // Accepted pixel
  input  logic                            accept,
  input  logic [sobh_pkg::PIXEL_W-1:0]    in_pixel,
  input  logic [sobh_pkg::ROW_W-1:0]      in_row,
  input  logic [CW-1:0]                   in_col,
  input  sobh_pkg::pos_flags_t            in_flags,
  output logic                            in_room,
  // Line buffer
  input  logic [sobh_pkg::LB_DATA_W-1:0]  mem_q,
  output logic                            mem_we,
  output logic [CW-1:0]                   mem_waddr,
  output logic [sobh_pkg::LB_DATA_W-1:0]  mem_wdata,
  // Output queue
  input  logic                            fifo_room,
  output logic [1:0]                      push_cnt,
  output logic [EW-1:0]                   push0,
  output logic [EW-1:0]                   push1
);

  localparam int PW = sobh_pkg::PIXEL_W;
  localparam int RW = sobh_pkg::ROW_W;

  logic                            st_valid;
  logic [PW-1:0]                   st_px;
  logic [RW-1:0]                   st_row;
  logic [CW-1:0]                   st_col;
  sobh_pkg::pos_flags_t            st_flags;
  logic                            st_fwd;
  logic [sobh_pkg::LB_DATA_W-1:0]  st_fwd_data;
  logic [PW-1:0]                   win [9];

  logic                            st_adv;
  logic                            fwd_next;
  logic [PW-1:0]                   up_rd;
  logic [PW-1:0]                   mid_rd;
  logic [PW+1:0]                   left_sum;
  logic [PW+1:0]                   right_sum;
  logic [PW+1:0]                   diff;
  logic [EW-1:0]                   int_entry;
  logic [EW-1:0]                   bord_entry;

  assign st_adv  = st_valid && fifo_room;
  assign in_room = !st_valid || fifo_room;

  // Take the previous row pair from the write-back when it hit the same column
  assign up_rd  = st_fwd ? st_fwd_data[2*PW-1:PW] : mem_q[2*PW-1:PW];
  assign mid_rd = st_fwd ? st_fwd_data[PW-1:0]    : mem_q[PW-1:0];

  // Shift the column: middle row moves up, new pixel becomes middle
  assign mem_we    = st_adv;
  assign mem_waddr = st_col;
  assign mem_wdata = {mid_rd, st_px};
  assign fwd_next  = accept && st_adv && (in_col == st_col);

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (st_adv) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_px       <= in_pixel;
      st_row      <= in_row;
      st_col      <= in_col;
      st_flags    <= in_flags;
      st_fwd      <= fwd_next;
      st_fwd_data <= mem_wdata;
    end
  end

  // Advance the 3x3 window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (st_adv) begin
      for (int i = 0; i < 3; i++) begin
        win[i*3]     <= win[i*3+1];
        win[i*3 + 1] <= win[i*3+2];
      end
      win[2] <= up_rd;
      win[5] <= mid_rd;
      win[8] <= st_px;
    end
  end

  // Left column minus right column, middle row doubled, keep low byte
  assign left_sum  = {2'b00, win[1]} + {1'b0, win[4], 1'b0} + {2'b00, win[7]};
  assign right_sum = {2'b00, up_rd} + {1'b0, mid_rd, 1'b0} + {2'b00, st_px};
  assign diff      = left_sum - right_sum;

  // Build result entries: {tlast, tuser, tdata}
  always_comb begin
    int_entry               = '0;
    int_entry[PW-1:0]       = diff[PW-1:0];
    int_entry[PW +: RW]     = st_row - RW'(1);
    int_entry[PW+RW +: CW]  = st_col - CW'(1);
    int_entry[DW]           = 1'b0;
    int_entry[DW+1]         = !st_flags.border;

    bord_entry              = '0;
    bord_entry[PW-1:0]      = st_px;
    bord_entry[PW +: RW]    = st_row;
    bord_entry[PW+RW +: CW] = st_col;
    bord_entry[DW]          = 1'b1;
    bord_entry[DW+1]        = 1'b1;
  end

  // Gradient first, border pass-through after it
  assign push0    = st_flags.interior ? int_entry : bord_entry;
  assign push1    = bord_entry;
  assign push_cnt = st_adv ? ({1'b0, st_flags.interior} + {1'b0, st_flags.border}) : 2'd0;

endmodule

// ----- sv/sobh_out_fifo.sv -----
// ----------------------------------------------------------------------------
// sobh_out_fifo
// Small result queue that takes up to two entries per cycle and hands one
// per transfer to the output stream.
// ----------------------------------------------------------------------------
module sobh_out_fifo #(
  parameter int EW = 34
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  logic [EW-1:0] push0,
  input  logic [EW-1:0] push1,
  output logic          room,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [EW-1:0] out_entry
);

  localparam int AW = sobh_pkg::FIFO_AW;
  localparam int CN = sobh_pkg::FIFO_CW;

  logic [EW-1:0] ent [sobh_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CN-1:0] count;
  logic          pop;

  assign out_valid = (count != '0);
  assign out_entry = ent[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for a full pair of results
  assign room      = (count <= CN'(sobh_pkg::FIFO_DEPTH - 2));

  // Store entries
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      ent[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      ent[wr_ptr + AW'(1)] <= push1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push_cnt);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count + CN'(push_cnt) - CN'(pop);
    end
  end

endmodule

// ----- sv/sobel_horizontal_3x3_stream.sv -----
// ----------------------------------------------------------------------------
// sobel_horizontal_3x3_stream
// Streaming 3x3 horizontal Sobel filter for 8-bit grayscale pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per clock; s_tuser high restarts the frame
// at row 0, column 0. Interior pixels produce the horizontal gradient (left
// column minus right column, middle row doubled) wrapped to 8 bits, emitted
// when the pixel one row down and one column right arrives; border pixels are
// passed through as they arrive with m_tuser high. A pixel yields zero, one or
// two results, the last flagged with m_tlast. Results pass through the kernel
// stage register and the result queue. The input takes one pixel per clock
// while the four-entry result queue has room for two results; the output
// drains one result per clock while m_tready is high, so in the last column
// and last row of a frame, where a pixel yields two results, the input is
// throttled by the output. After reset the line buffer is swept to zero with
// s_tready low; configuration writes are taken at any time.
module sobel_horizontal_3x3_stream #(
  parameter  int MAX_WIDTH = 512,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int DW        = ((sobh_pkg::PIXEL_W + sobh_pkg::ROW_W + CW + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // Pixel input
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sobh_pkg::PIXEL_W-1:0]     s_tdata,   // [7:0] pixel
  input  logic                             s_tuser,   // frame_start
  // Result output
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [DW-1:0]                    m_tdata,   // out_value, out_row, out_col, zero pad
  output logic                             m_tuser,   // is_border
  output logic                             m_tlast,   // last_of_run
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [sobh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW = CW + 1;
  localparam int RW = sobh_pkg::ROW_W;
  localparam int EW = DW + 2;

  logic [sobh_pkg::FWIDTH_W-1:0]   frame_width;
  logic [sobh_pkg::FHEIGHT_W-1:0]  frame_height;
  logic [RW-1:0]                   row_count;
  logic [CW-1:0]                   col_count;

  logic [WW-1:0]                   eff_w;
  logic [WW-1:0]                   w_m1;
  logic [RW-1:0]                   eff_h;
  logic [RW-1:0]                   h_m1;
  logic [RW-1:0]                   r0;
  logic [CW-1:0]                   c0;
  logic [WW-1:0]                   c_inc;
  logic [RW:0]                     r_inc;
  logic [RW-1:0]                   row_next;
  logic [CW-1:0]                   col_next;
  sobh_pkg::pos_flags_t            flags;
  logic                            accept;

  logic                            lb_busy;
  logic [sobh_pkg::LB_DATA_W-1:0]  lb_q;
  logic                            lb_we;
  logic [CW-1:0]                   lb_waddr;
  logic [sobh_pkg::LB_DATA_W-1:0]  lb_wdata;
  logic                            k_room;
  logic                            fifo_room;
  logic [1:0]                      push_cnt;
  logic [EW-1:0]                   push0;
  logic [EW-1:0]                   push1;
  logic [EW-1:0]                   out_entry;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= sobh_pkg::FWIDTH_W'(512);
      frame_height <= sobh_pkg::FHEIGHT_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sobh_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[sobh_pkg::FWIDTH_W-1:0];
        sobh_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[sobh_pkg::FHEIGHT_W-1:0];
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  // Clamp frame size into the supported range
  always_comb begin
    priority if (32'(frame_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else if (frame_width < sobh_pkg::FWIDTH_W'(3)) begin
      eff_w = WW'(3);
    end else begin
      eff_w = WW'(frame_width);
    end
    eff_h = (frame_height < RW'(3)) ? RW'(3) : frame_height;
  end

  assign w_m1 = eff_w - WW'(1);
  assign h_m1 = eff_h - RW'(1);

  // Position of the arriving pixel
  assign r0 = s_tuser ? '0 : row_count;
  assign c0 = s_tuser ? '0 : col_count;

  assign flags.interior = (r0 >= RW'(2)) && (c0 >= CW'(2)) &&
                          (r0 <= h_m1) && ({1'b0, c0} <= w_m1);
  assign flags.border   = (r0 == '0) || (c0 == '0) ||
                          (r0 >= h_m1) || ({1'b0, c0} >= w_m1);

  // Raster counters
  assign c_inc = {1'b0, c0} + WW'(1);
  assign r_inc = {1'b0, r0} + (RW+1)'(1);

  always_comb begin
    if (c_inc >= eff_w) begin
      col_next = '0;
      row_next = (r_inc >= {1'b0, eff_h}) ? '0 : r_inc[RW-1:0];
    end else begin
      col_next = c_inc[CW-1:0];
      row_next = r0;
    end
  end

  assign s_tready = !lb_busy && k_room;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_next;
      col_count <= col_next;
    end
  end

  sobh_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (c0),
    .rd_data (lb_q),
    .wr_en   (lb_we),
    .wr_addr (lb_waddr),
    .wr_data (lb_wdata),
    .busy    (lb_busy)
  );

  sobh_kernel #(
    .CW (CW),
    .DW (DW),
    .EW (EW)
  ) u_kernel (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_pixel  (s_tdata),
    .in_row    (r0),
    .in_col    (c0),
    .in_flags  (flags),
    .in_room   (k_room),
    .mem_q     (lb_q),
    .mem_we    (lb_we),
    .mem_waddr (lb_waddr),
    .mem_wdata (lb_wdata),
    .fifo_room (fifo_room),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1)
  );

  sobh_out_fifo #(
    .EW (EW)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .room      (fifo_room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_entry (out_entry)
  );

  assign m_tdata = out_entry[DW-1:0];
  assign m_tuser = out_entry[DW];
  assign m_tlast = out_entry[DW+1];

endmodule

// ----- sv/sobh_checker.sv -----
// ----------------------------------------------------------------------------
// sobh_checker
// Port-level checks for the horizontal Sobel stream, bound to the top level.
// ----------------------------------------------------------------------------
module sobh_checker #(
  parameter  int MAX_WIDTH = 512,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int DW        = ((sobh_pkg::PIXEL_W + sobh_pkg::ROW_W + CW + 7) / 8) * 8
) (
  input logic          clk,
  input logic          rst,
  input logic          s_tready,
  input logic          m_tvalid,
  input logic          m_tready,
  input logic [DW-1:0] m_tdata,
  input logic          m_tuser,
  input logic          m_tlast,
  input logic          cfg_valid,
  input logic          cfg_ready
);

  localparam int RO = sobh_pkg::PIXEL_W;
  localparam int CO = sobh_pkg::PIXEL_W + sobh_pkg::ROW_W;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                              $stable(m_tuser) && $stable(m_tlast))
    else $error("stalled result changed");

  // Gradients only belong to pixels off the first row and column
  a_grad_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[RO +: sobh_pkg::ROW_W] != '0) &&
                             (m_tdata[CO +: CW] != '0))
    else $error("gradient on first row or column");

  // Line buffer sweep keeps the input closed right after reset
  a_clear_block: assert property (@(posedge clk)
    $fell(rst) |-> !s_tready)
    else $error("input open during line buffer clear");

  // Configuration writes always complete
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind sobel_horizontal_3x3_stream sobh_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_sobh_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tuser   (m_tuser),
  .m_tlast   (m_tlast),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 horizontal Sobel stream filter.
// ----------------------------------------------------------------------------
// A table of directed rows runs first: extreme pixels at the default frame
// size, then two 3x3 frames whose gradients are typed in. Random phases follow.
// Each phase writes a new frame size, which can be out of range or smaller
// than the current counter position, and streams runs of random pixels, with
// stray frame starts and frames that wrap without one. A bit-exact predictor
// builds the expected results. The sender runs in bursts and the receiver
// stalls in changing patterns, with one long hold-off that backs the filter
// up into its input.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sobh_pkg::*;

  localparam int MAX_W         = 512;
  localparam int MAX_H         = 4095;
  localparam int COL_W         = $clog2(MAX_W);
  localparam int DW            = ((PIXEL_W + ROW_W + COL_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 730;
  localparam int PLAN_ROWS     = 25;

  // One result of the filter, in the order of the output fields
  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               border;
    logic               last;
  } pix_result_t;

  typedef enum logic [1:0] {
    ACT_PIXEL,
    ACT_WRITE,
    ACT_SETTLE
  } step_kind_t;

  // Directed row: typed rows give the first result of that pixel by hand
  typedef struct packed {
    step_kind_t            kind;
    logic                  reg_sel;
    logic [CFG_DATA_W-1:0] data;
    logic                  sof;
    logic                  typed;
    pix_result_t           fix;
  } plan_row_t;

  localparam pix_result_t NO_FIX = '0;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [PIXEL_W-1:0]    s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [DW-1:0]         m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state
  logic [PIXEL_W-1:0] upper_line  [MAX_W];
  logic [PIXEL_W-1:0] middle_line [MAX_W];
  logic [PIXEL_W-1:0] win [9];
  int                 col_pos;
  int                 row_pos;
  int                 fw_reg;
  int                 fh_reg;
  pix_result_t        pending_results [$];

  int errors;
  int cycles;
  int burst_left;
  bit cfg_open;
  bit hold_req;

  plan_row_t plan [PLAN_ROWS] = '{
    // default 512x512 frame: row 0 passes through
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b1, 1'b1, '{8'h00, 12'd0, 9'd0, 1'b1, 1'b1}},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b1, '{8'hFF, 12'd0, 9'd1, 1'b1, 1'b1}},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h05A, 1'b0, 1'b0, NO_FIX},
    '{ACT_SETTLE, REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX},
    '{ACT_WRITE,  REG_FRAME_WIDTH,  12'd3,   1'b0, 1'b0, NO_FIX},
    '{ACT_WRITE,  REG_FRAME_HEIGHT, 12'd3,   1'b0, 1'b0, NO_FIX},
    // smallest frame, left column full scale: gradient 1020 wraps to 252
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b1, 1'b1, '{8'hFF, 12'd0, 9'd0, 1'b1, 1'b1}},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h080, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h007, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h009, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b1, '{8'd252, 12'd1, 9'd1, 1'b0, 1'b0}},
    // right column full scale: gradient -1020 wraps to 4
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b1, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h033, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h044, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h055, 1'b0, 1'b0, NO_FIX},
    '{ACT_PIXEL,  REG_FRAME_WIDTH,  12'h0FF, 1'b0, 1'b1, '{8'd4, 12'd1, 9'd1, 1'b0, 1'b0}},
    '{ACT_SETTLE, REG_FRAME_WIDTH,  12'h000, 1'b0, 1'b0, NO_FIX}
  };

  sobel_horizontal_3x3_stream #(.MAX_WIDTH(MAX_W)) DUT (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Frame size as the filter sees it, saturated into the legal range
  function automatic int eff_width();
    return (fw_reg < 3) ? 3 : (fw_reg > MAX_W) ? MAX_W : fw_reg;
  endfunction

  function automatic int eff_height();
    return (fh_reg < 3) ? 3 : (fh_reg > MAX_H) ? MAX_H : fh_reg;
  endfunction

  // Advance the window by one pixel and queue the results it causes
  function automatic int predict_pixel(input logic [PIXEL_W-1:0] px, input logic sof);
    int                 w;
    int                 h;
    int                 r;
    int                 c;
    int                 n;
    int                 left;
    int                 right;
    bit                 at_border;
    logic [PIXEL_W-1:0] up;
    logic [PIXEL_W-1:0] md;
    pix_result_t        res;
    w = eff_width();
    h = eff_height();
    n = 0;
    if (sof) begin
      col_pos = 0;
      row_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    // rotate the column through the line buffers
    up = upper_line[c];
    md = middle_line[c];
    upper_line[c]  = md;
    middle_line[c] = px;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = up;
    win[5] = md;
    win[8] = px;
    at_border = (r == 0) || (c == 0) || (r >= h - 1) || (c >= w - 1);
    // gradient of the pixel up and to the left comes first
    if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1) begin
      left  = int'(win[0]) + 2 * int'(win[3]) + int'(win[6]);
      right = int'(win[2]) + 2 * int'(win[5]) + int'(win[8]);
      res.value  = PIXEL_W'(left - right);
      res.row    = ROW_W'(r - 1);
      res.col    = COL_W'(c - 1);
      res.border = 1'b0;
      res.last   = !at_border;
      pending_results.push_back(res);
      n++;
    end
    if (at_border) begin
      res.value  = px;
      res.row    = ROW_W'(r);
      res.col    = COL_W'(c);
      res.border = 1'b1;
      res.last   = 1'b1;
      pending_results.push_back(res);
      n++;
    end
    // raster advance, wrapping at the end of the frame
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return n;
  endfunction

  // Drop the config valid left up by the last register write
  task automatic close_cfg();
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
  endtask

  task automatic write_reg(input logic sel, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    cfg_open = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (sel == REG_FRAME_WIDTH) fw_reg = int'(data[FWIDTH_W-1:0]);
    else fh_reg = int'(data[FHEIGHT_W-1:0]);
  endtask

  // Offer one pixel, idling between bursts, and predict on transfer
  task automatic push_pixel(input logic [PIXEL_W-1:0] px, input logic sof, input bit steady,
                            input bit typed, input pix_result_t fix);
    int gap;
    int n;
    close_cfg();
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tuser  <= sof;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    n = predict_pixel(px, sof);
    if (typed && n > 0) pending_results[pending_results.size() - n] = fix;
  endtask

  // Stop offering, let every expected result drain, then let the pipe empty
  task automatic settle();
    close_cfg();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall pattern is redrawn at random, long hold-off on request
  initial begin
    int rx_tick;
    int rx_mode;
    rx_tick  = 0;
    rx_mode  = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (rx_tick % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick % 4 != 0);
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.value  = m_tdata[PIXEL_W-1:0];
      got.row    = m_tdata[PIXEL_W+ROW_W-1:PIXEL_W];
      got.col    = m_tdata[PIXEL_W+ROW_W+COL_W-1:PIXEL_W+ROW_W];
      got.border = m_tuser;
      got.last   = m_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected result: expected none, got value=%0d row=%0d",
                   $time, got.value, got.row, " col=%0d border=%0b last=%0b",
                   got.col, got.border, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 20)
            $display("%0t: result mismatch: expected value=%0d row=%0d col=%0d",
                     $time, want.value, want.row, want.col,
                     " border=%0b last=%0b, got value=%0d row=%0d col=%0d",
                     want.border, want.last, got.value, got.row, got.col,
                     " border=%0b last=%0b", got.border, got.last);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("sobel_horizontal_3x3_stream verification failed");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int                    phase;
    int                    count;
    int                    ew;
    int                    eh;
    int                    sel;
    int                    rand_items;
    bit                    start_sof;
    bit                    steady;
    logic [PIXEL_W-1:0]    px;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;

    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_FRAME_WIDTH;
    cfg_data   = '0;
    errors     = 0;
    burst_left = 0;
    cfg_open   = 1'b0;
    hold_req   = 1'b0;
    fw_reg     = MAX_W;
    fh_reg     = MAX_W;
    col_pos    = 0;
    row_pos    = 0;
    for (int i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    foreach (plan[i]) begin
      case (plan[i].kind)
        ACT_PIXEL:  push_pixel(plan[i].data[PIXEL_W-1:0], plan[i].sof, 1'b0,
                               plan[i].typed, plan[i].fix);
        ACT_WRITE:  write_reg(plan[i].reg_sel, plan[i].data);
        default:    settle();
      endcase
    end

    // Random phases: new frame size, then runs of random pixels
    phase      = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      phase++;
      settle();
      wd = CFG_DATA_W'($urandom_range(0, 4095));
      case ($urandom_range(0, 9))
        0:       wd[FWIDTH_W-1:0] = FWIDTH_W'($urandom_range(0, 2));
        1:       wd[FWIDTH_W-1:0] = FWIDTH_W'($urandom_range(MAX_W, 1023));
        2:       wd[FWIDTH_W-1:0] = FWIDTH_W'($urandom_range(11, MAX_W - 1));
        default: wd[FWIDTH_W-1:0] = FWIDTH_W'($urandom_range(3, 10));
      endcase
      case ($urandom_range(0, 9))
        0:       hd = CFG_DATA_W'($urandom_range(0, 2));
        1:       hd = CFG_DATA_W'(MAX_H);
        2:       hd = CFG_DATA_W'($urandom_range(9, MAX_H - 1));
        default: hd = CFG_DATA_W'($urandom_range(3, 8));
      endcase
      sel = $urandom_range(0, 4);
      // full-width row with all width bits set; small frame for the hold-off
      if (phase == 1) begin
        wd  = '1;
        hd  = 12'd3;
        sel = 0;
      end
      if (phase == 2) begin
        wd  = 12'd8;
        hd  = 12'd8;
        sel = 0;
      end
      // sometimes only one register, so counters may sit past the new edge
      if (sel != 1) write_reg(REG_FRAME_WIDTH, wd);
      if (sel != 2) write_reg(REG_FRAME_HEIGHT, hd);
      ew = eff_width();
      eh = eff_height();
      if (phase == 1) count = ew + 4;
      else if (ew * eh <= 120) count = $urandom_range(1, 3) * ew * eh + $urandom_range(0, ew);
      else count = $urandom_range(ew / 2, ew + 30);
      // keep the run near the item budget
      if (count > RANDOM_ITEMS - rand_items) count = RANDOM_ITEMS - rand_items;
      start_sof = (phase <= 3) || ($urandom_range(0, 3) != 0);
      steady    = (phase == 2) || ($urandom_range(0, 3) == 0);
      if (phase == 2) hold_req = 1'b1;
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(0, 3) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else px = PIXEL_W'($urandom_range(0, 255));
        push_pixel(px, (k == 0 && start_sof) || ($urandom_range(0, 49) == 0), steady,
                   1'b0, NO_FIX);
      end
      rand_items += count;
    end

    settle();
    if (errors == 0) begin
      $display("sobel_horizontal_3x3_stream verification clean");
    end else begin
      $display("sobel_horizontal_3x3_stream verification failed");
    end
    $finish;
  end

endmodule
